[hw/rtl/utf8_stream_decoder_defines.svh]
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8sd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8sd assertion failed");

`endif

[hw/rtl/u8sd_pkg.sv]
// Types, status codes and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps
package u8sd_pkg;

    localparam logic [20:0] CpMax     = 21'h10FFFF;
    localparam logic [20:0] SurrFirst = 21'h00D800;
    localparam logic [20:0] SurrLast  = 21'h00DFFF;

    localparam logic [2:0] StatusOk       = 3'd0;
    localparam logic [2:0] StatusBadLead  = 3'd1;
    localparam logic [2:0] StatusTrunc    = 3'd2;
    localparam logic [2:0] StatusBadCont  = 3'd3;
    localparam logic [2:0] StatusBadValue = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } u8sd_in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  status;
        logic        text_done;
    } u8sd_out_t;

    // Smallest value that a sequence with the given continuation count may encode.
    function automatic logic [20:0] min_value(input logic [1:0] seq_class);
        logic [20:0] v;
        case (seq_class)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/utf8_stream_decoder.sv]
// Strict streaming UTF-8 decoder: one byte in per transfer, one result per sequence.
// Decode is combinational; a result is registered and shows at m_data in the next cycle.
// Throughput: one byte per cycle, stalled while a held result waits on m_ready.
// Reset: synchronous active-low aresetn clears the sequence state and the result valid.
`timescale 1ns / 1ps
module utf8_stream_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u8sd_pkg::u8sd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output u8sd_pkg::u8sd_out_t m_data
);
    import u8sd_pkg::*;
    `include "utf8_stream_decoder_defines.svh"

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] acc_reg, acc_next;
    logic [1:0]  class_reg, class_next;
    logic        badc_reg, badc_next;
    logic        skip_reg, skip_next;
    logic        m_valid_reg, m_valid_next;
    u8sd_out_t   out_reg, out_next;

    logic        accept;
    logic        emit;
    u8sd_out_t   res;
    logic [7:0]  b;
    logic        eot;
    logic [1:0]  need;
    logic [20:0] bits;
    logic        lead_ok;
    logic [20:0] cp;
    logic [1:0]  pend_dec;
    logic        badc_acc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign b       = s_data.data_byte;
    assign eot     = s_data.end_of_text;

    always_comb begin
        lead_ok = 1'b1;
        need    = 2'd0;
        bits    = {13'd0, b};
        if (b[7] == 1'b0) begin
            need = 2'd0;
            bits = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            need = 2'd1;
            bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            need = 2'd2;
            bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            need = 2'd3;
            bits = {18'd0, b[2:0]};
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign cp       = {acc_reg[14:0], b[5:0]};
    assign pend_dec = pending_reg - 2'd1;
    assign badc_acc = badc_reg || (b[7:6] != 2'b10);

    always_comb begin
        pending_next = pending_reg;
        acc_next     = acc_reg;
        class_next   = class_reg;
        badc_next    = badc_reg;
        skip_next    = skip_reg;
        emit         = 1'b0;
        res          = '{code_point: 21'd0, status: StatusOk, text_done: eot};

        if (skip_reg) begin
            if (eot) begin
                skip_next = 1'b0;
            end
        end else if (pending_reg == 2'd0) begin
            if (!lead_ok) begin
                emit = 1'b1;
                res  = '{code_point: 21'd0, status: StatusBadLead, text_done: 1'b1};
                skip_next = !eot;
            end else if (need == 2'd0) begin
                emit = 1'b1;
                res  = '{code_point: bits, status: StatusOk, text_done: eot};
            end else if (eot) begin
                emit = 1'b1;
                res  = '{code_point: 21'd0, status: StatusTrunc, text_done: 1'b1};
            end else begin
                pending_next = need;
                class_next   = need;
                acc_next     = bits;
                badc_next    = 1'b0;
            end
        end else if (pend_dec != 2'd0) begin
            if (eot) begin
                emit = 1'b1;
                res  = '{code_point: 21'd0, status: StatusTrunc, text_done: 1'b1};
                pending_next = 2'd0;
                acc_next     = 21'd0;
                class_next   = 2'd0;
                badc_next    = 1'b0;
            end else begin
                pending_next = pend_dec;
                acc_next     = cp;
                badc_next    = badc_acc;
            end
        end else begin
            emit         = 1'b1;
            pending_next = 2'd0;
            acc_next     = 21'd0;
            class_next   = 2'd0;
            badc_next    = 1'b0;
            if (badc_acc) begin
                res = '{code_point: 21'd0, status: StatusBadCont, text_done: 1'b1};
                skip_next = !eot;
            end else if (cp < min_value(class_reg) || cp > CpMax ||
                         (cp >= SurrFirst && cp <= SurrLast)) begin
                res = '{code_point: 21'd0, status: StatusBadValue, text_done: 1'b1};
                skip_next = !eot;
            end else begin
                res = '{code_point: cp, status: StatusOk, text_done: eot};
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (s_ready) begin
            m_valid_next = accept && emit;
            if (accept && emit) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            acc_reg     <= 21'd0;
            class_reg   <= 2'd0;
            badc_reg    <= 1'b0;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                pending_reg <= pending_next;
                acc_reg     <= acc_next;
                class_reg   <= class_next;
                badc_reg    <= badc_next;
                skip_reg    <= skip_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    `U8SD_ASSERT_NOW(a_err_result_ends_text, aclk, aresetn, m_valid_reg && out_reg.status != StatusOk, out_reg.code_point == 21'd0 && out_reg.text_done)
    `U8SD_ASSERT_NOW(a_ok_result_is_scalar, aclk, aresetn, m_valid_reg && out_reg.status == StatusOk, out_reg.code_point <= CpMax && (out_reg.code_point < SurrFirst || out_reg.code_point > SurrLast))
    `U8SD_ASSERT_NOW(a_skip_has_no_sequence, aclk, aresetn, skip_reg, pending_reg == 2'd0)
    `U8SD_ASSERT_NEXT(a_end_clears_state, aclk, aresetn, accept && s_data.end_of_text, pending_reg == 2'd0 && !skip_reg && !badc_reg)

endmodule

[bench/utf8_decoder_checker.sv]
// Scoreboard for the UTF-8 stream decoder: predicts each code point or error and checks the results.
`timescale 1ns / 1ps
module utf8_decoder_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  u8sd_pkg::u8sd_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  u8sd_pkg::u8sd_out_t m_data,
    output int                  fail_count,
    output int                  outstanding
);
    import u8sd_pkg::*;

    u8sd_out_t   expected_chars[$];

    logic [1:0]  cont_left;
    logic [20:0] scalar_acc;
    logic [1:0]  seq_len_class;
    logic        cont_broken;
    logic        dropping;

    function automatic bit decode_byte(input u8sd_in_t item, output u8sd_out_t res);
        logic [7:0]  b;
        logic [2:0]  err;
        logic [20:0] floor_val;
        bit          emits;
        b     = item.data_byte;
        err   = StatusOk;
        emits = 1'b0;
        res   = '0;
        if (dropping) begin
            if (item.end_of_text) begin
                dropping = 1'b0;
            end
            return 1'b0;
        end
        if (cont_left == 2'd0) begin
            if (!b[7]) begin
                emits           = 1'b1;
                res.code_point  = {14'd0, b[6:0]};
            end else if (b[7:5] == 3'b110) begin
                cont_left  = 2'd1;
                scalar_acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                cont_left  = 2'd2;
                scalar_acc = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                cont_left  = 2'd3;
                scalar_acc = {18'd0, b[2:0]};
            end else begin
                err = StatusBadLead;
            end
            seq_len_class = cont_left;
            cont_broken   = 1'b0;
            if (cont_left != 2'd0 && item.end_of_text) begin
                err = StatusTrunc;
            end
        end else begin
            if (b[7:6] != 2'b10) begin
                cont_broken = 1'b1;
            end
            scalar_acc = {scalar_acc[14:0], b[5:0]};
            cont_left  = cont_left - 2'd1;
            if (cont_left != 2'd0) begin
                if (item.end_of_text) begin
                    err = StatusTrunc;
                end
            end else if (cont_broken) begin
                err = StatusBadCont;
            end else begin
                case (seq_len_class)
                    2'd1:    floor_val = 21'h000080;
                    2'd2:    floor_val = 21'h000800;
                    2'd3:    floor_val = 21'h010000;
                    default: floor_val = 21'h000000;
                endcase
                if (scalar_acc < floor_val || scalar_acc > CpMax ||
                    (scalar_acc >= SurrFirst && scalar_acc <= SurrLast)) begin
                    err = StatusBadValue;
                end else begin
                    emits          = 1'b1;
                    res.code_point = scalar_acc;
                end
            end
        end
        if (err != StatusOk) begin
            emits          = 1'b1;
            res.code_point = '0;
            res.text_done  = 1'b1;
            dropping       = !item.end_of_text;
        end else begin
            res.text_done = item.end_of_text;
        end
        res.status = err;
        if (emits) begin
            cont_left     = 2'd0;
            scalar_acc    = '0;
            seq_len_class = 2'd0;
            cont_broken   = 1'b0;
        end
        return emits;
    endfunction

    always @(posedge aclk) begin : watch
        u8sd_out_t want;
        u8sd_out_t predicted;
        if (!aresetn) begin
            expected_chars.delete();
            cont_left     = 2'd0;
            scalar_acc    = '0;
            seq_len_class = 2'd0;
            cont_broken   = 1'b0;
            dropping      = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result cp=%h status=%0d done=%b", $time,
                                 m_data.code_point, m_data.status, m_data.text_done);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.code_point !== want.code_point ||
                        m_data.status !== want.status ||
                        m_data.text_done !== want.text_done) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: expected cp=%h status=%0d done=%b,", $time,
                                     want.code_point, want.status, want.text_done);
                            $display("    got cp=%h status=%0d done=%b",
                                     m_data.code_point, m_data.status, m_data.text_done);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (decode_byte(s_data, predicted)) begin
                    expected_chars.insert(expected_chars.size(), predicted);
                end
            end
        end
        outstanding = expected_chars.size();
    end

endmodule

[bench/utf8_stream_decoder_tb.sv]
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus, result sink and verdict.
`timescale 1ns / 1ps
module utf8_stream_decoder_tb;
    import u8sd_pkg::*;

    localparam int ITEM_GOAL    = 1200;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum int {
        FaultBadLead,
        FaultTrunc,
        FaultBadCont,
        FaultOverlong,
        FaultSurrogate,
        FaultTooBig
    } fault_e;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    u8sd_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    u8sd_out_t m_data;

    int        fail_count;
    int        outstanding;
    int        items_sent   = 0;
    int        hold_req     = 0;
    bit        src_idle_en  = 1'b1;
    bit        sink_idle_en = 1'b1;
    logic [7:0] text_bytes[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    utf8_stream_decoder uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    utf8_decoder_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic void add_byte(input logic [7:0] bval);
        text_bytes.insert(text_bytes.size(), bval);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eot);
        int gap;
        @(negedge aclk);
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= {b, eot};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            push_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    function automatic logic [20:0] random_scalar(input int len);
        logic [20:0] v;
        case (len)
            1:       v = 21'($urandom_range(0, 'h7F));
            2:       v = 21'($urandom_range('h80, 'h7FF));
            3: begin
                v = 21'($urandom_range('h800, 'hFFFF));
                if (v >= SurrFirst && v <= SurrLast) begin
                    v = v + 21'h800;
                end
            end
            default: v = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return v;
    endfunction

    task automatic append_utf8(input logic [20:0] cp, input int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // One text in ten is random bytes; of the rest, about a third carry one fault, later bytes dropped.
    task automatic build_text();
        int          n;
        int          fault_at;
        int          len;
        int          idx;
        fault_e      fault;
        logic [7:0]  b;
        logic [20:0] ceiling;
        text_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) add_byte(8'($urandom));
            return;
        end
        n        = $urandom_range(1, 6);
        fault_at = ($urandom_range(0, 99) < 35) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            len = $urandom_range(1, 4);
            if (i != fault_at) begin
                append_utf8(random_scalar(len), len);
            end else begin
                fault = fault_e'($urandom_range(0, 5));
                len   = $urandom_range(2, 4);
                case (fault)
                    FaultBadLead: begin
                        if ($urandom_range(0, 1) == 0) begin
                            add_byte(8'($urandom_range('h80, 'hBF)));
                        end else begin
                            add_byte(8'($urandom_range('hF8, 'hFF)));
                        end
                    end
                    FaultTrunc: begin
                        append_utf8(random_scalar(len), len);
                        repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
                        break;
                    end
                    FaultBadCont: begin
                        append_utf8(random_scalar(len), len);
                        idx = text_bytes.size() - $urandom_range(1, len - 1);
                        b   = 8'($urandom);
                        if (b[7:6] == 2'b10) begin
                            b[7] = 1'b0;
                        end
                        text_bytes[idx] = b;
                    end
                    FaultOverlong: begin
                        case (len)
                            2:       ceiling = 21'h00007F;
                            3:       ceiling = 21'h0007FF;
                            default: ceiling = 21'h00FFFF;
                        endcase
                        append_utf8(21'($urandom_range(0, ceiling)), len);
                    end
                    FaultSurrogate: append_utf8(21'($urandom_range(SurrFirst, SurrLast)), 3);
                    default:        append_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
                endcase
            end
        end
    endtask

    initial begin : sink
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        text_bytes = '{8'h00, 8'h7F};
        send_text();
        text_bytes = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        text_bytes = '{8'h80, 8'h41};
        send_text();
        text_bytes = '{8'hFF};
        send_text();
        text_bytes = '{8'hE0};
        send_text();
        text_bytes = '{8'hE2, 8'h41};
        send_text();
        text_bytes = '{8'hE2, 8'h41, 8'h80, 8'hF8};
        send_text();
        text_bytes = '{8'hC0, 8'h80};
        send_text();
        text_bytes = '{8'hED, 8'hA0, 8'h80};
        send_text();
        text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_text();

        while (items_sent < ITEM_GOAL) begin
            if (!hold_done && items_sent >= 300) begin
                hold_done = 1'b1;
                hold_req++;
            end
            if (!pause_done && items_sent >= 650) begin
                pause_done = 1'b1;
                @(negedge aclk);
                s_valid <= 1'b0;
                wait (outstanding == 0);
            end
            if (items_sent >= ITEM_GOAL - 150) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            build_text();
            send_text();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
